@@ sv/mm4_pkg.sv @@
`timescale 1ns / 1ps
// mm4_pkg: shared constants, payload and command types for the 4x4 matrix multiplier.
// No dependencies; imported by every module of the block.
package mm4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;

  localparam int SLOTS     = DIM * DIM;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int IDX_W     = $clog2(DIM);
  // Truncated product needs 64-FRAC_BITS bits, the DIM-term sum clog2(DIM) more.
  localparam int ACC_W     = 64 - FRAC_BITS + $clog2(DIM);

  localparam int CQ_DEPTH  = 4;
  localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W  = CQ_PTR_W + 1;

  localparam logic [0:0] TGT_LEFT = 1'b0;

  typedef struct packed {
    logic               target_matrix;
    logic [1:0]         elem_row;
    logic [1:0]         elem_col;
    logic signed [31:0] elem_value;
    logic               start_multiply;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] product_value;
    logic [1:0]         product_row;
    logic [1:0]         product_col;
    logic               last_result;
  } out_item_t;

  // Classified load request as it sits in the command queue.
  typedef struct packed {
    logic               target;
    logic               wr_en;
    logic [SLOT_W-1:0]  slot;
    logic signed [31:0] value;
    logic               start;
  } cmd_t;

  typedef struct packed {
    logic                full;
    logic                empty;
    logic [CQ_CNT_W-1:0] count;
  } q_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

@@ sv/mm4_front.sv @@
`timescale 1ns / 1ps
// mm4_front: input handshake and classification of load requests into queue commands.
// Depends on mm4_pkg.
module mm4_front import mm4_pkg::*; (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic in_range;

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  // Loads outside the DIM x DIM grid are dropped, a start flag on them still counts.
  assign in_range = (int'(in_item.elem_row) < DIM) && (int'(in_item.elem_col) < DIM);

  always_comb begin
    q_cmd.target = in_item.target_matrix;
    q_cmd.wr_en  = in_range;
    q_cmd.slot   = SLOT_W'(SLOT_W'(in_item.elem_row) * SLOT_W'(DIM)
                   + SLOT_W'(in_item.elem_col));
    q_cmd.value  = in_item.elem_value;
    q_cmd.start  = in_item.start_multiply;
  end

endmodule

@@ sv/mm4_cmdq.sv @@
`timescale 1ns / 1ps
// mm4_cmdq: small FIFO of load commands between the front and back parts.
// Depends on mm4_pkg.
module mm4_cmdq import mm4_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t                entry_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign stat.count = count_r;
  assign stat.full  = (count_r == CQ_CNT_W'(CQ_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = entry_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/mm4_back.sv @@
`timescale 1ns / 1ps
// mm4_back: operand stores, MAC sequencer, pipelined multiply-accumulate and result register.
// Depends on mm4_pkg.
module mm4_back import mm4_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
    logic             last_term;
    logic             last_elem;
  } tag_t;

  back_state_t state_r, state_nxt;

  logic signed [31:0] left_mem  [SLOTS];
  logic signed [31:0] right_mem [SLOTS];

  logic [IDX_W-1:0]   r_r, r_nxt, c_r, c_nxt, i_r, i_nxt;
  logic               issue_vld, issue_fire, last_issue, adv;
  logic               r_max, c_max, i_max;
  logic [SLOT_W-1:0]  a_addr, b_addr;
  tag_t               issue_tag;

  logic               s1_vld_r, s2_vld_r;
  tag_t               s1_tag_r, s2_tag_r;
  logic signed [31:0] a_rd_r, b_rd_r;
  logic signed [63:0] prod_r;

  logic signed [ACC_W-1:0] term, acc_sum, acc_r;
  logic [ACC_W-32:0]       acc_hi;
  logic signed [31:0]      sat_value;
  logic                    done;

  logic      out_valid_r;
  out_item_t out_item_r;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Whole pipeline moves together; it holds only while a result waits at the output.
  assign adv = !out_valid_r || out_ready;

  assign r_max      = (r_r == IDX_W'(DIM - 1));
  assign c_max      = (c_r == IDX_W'(DIM - 1));
  assign i_max      = (i_r == IDX_W'(DIM - 1));
  assign issue_vld  = (state_r == BK_RUN);
  assign issue_fire = issue_vld && adv;
  assign last_issue = issue_fire && r_max && c_max && i_max;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_pop && q_head.start) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (last_issue) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs: loads are taken only between multiplies
  always_comb begin
    q_pop = 1'b0;
    case (state_r)
      BK_IDLE: q_pop = !q_stat.empty;
      BK_RUN:  q_pop = 1'b0;
      default: q_pop = 1'b0;
    endcase
  end

  // i runs fastest, then column, then row
  always_comb begin
    i_nxt = i_max ? '0 : i_r + 1'b1;
    c_nxt = c_r;
    r_nxt = r_r;
    if (i_max) begin
      c_nxt = c_max ? '0 : c_r + 1'b1;
      if (c_max) begin
        r_nxt = r_max ? '0 : r_r + 1'b1;
      end
    end
  end

  assign a_addr = SLOT_W'(SLOT_W'(r_r) * SLOT_W'(DIM) + SLOT_W'(i_r));
  assign b_addr = SLOT_W'(SLOT_W'(i_r) * SLOT_W'(DIM) + SLOT_W'(c_r));

  always_comb begin
    issue_tag.row       = r_r;
    issue_tag.col       = c_r;
    issue_tag.first     = (i_r == '0);
    issue_tag.last_term = i_max;
    issue_tag.last_elem = r_max && c_max;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      r_r         <= '0;
      c_r         <= '0;
      i_r         <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (issue_fire) begin
        r_r <= r_nxt;
        c_r <= c_nxt;
        i_r <= i_nxt;
      end
      if (adv) begin
        s1_vld_r    <= issue_vld;
        s2_vld_r    <= s1_vld_r;
        out_valid_r <= done;
      end
    end
  end

  // Operand stores
  always_ff @(posedge clk) begin
    if (q_pop && q_head.wr_en) begin
      if (q_head.target == TGT_LEFT) begin
        left_mem[q_head.slot] <= q_head.value;
      end else begin
        right_mem[q_head.slot] <= q_head.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rd_r   <= left_mem[a_addr];
      b_rd_r   <= right_mem[b_addr];
      s1_tag_r <= issue_tag;
      prod_r   <= 64'(a_rd_r) * 64'(b_rd_r);
      s2_tag_r <= s1_tag_r;
    end
  end

  // Arithmetic shift floors the product; sum is exact in ACC_W bits.
  assign term    = ACC_W'(prod_r >>> FRAC_BITS);
  assign acc_sum = s2_tag_r.first ? term : acc_r + term;
  assign done    = s2_vld_r && s2_tag_r.last_term;
  assign acc_hi  = acc_sum[ACC_W-1:31];

  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      sat_value = acc_sum[31:0];
    end else if (acc_sum[ACC_W-1]) begin
      sat_value = 32'sh8000_0000;
    end else begin
      sat_value = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_vld_r) begin
      acc_r <= acc_sum;
    end
    if (adv && done) begin
      out_item_r.product_value <= sat_value;
      out_item_r.product_row   <= 2'(s2_tag_r.row);
      out_item_r.product_col   <= 2'(s2_tag_r.col);
      out_item_r.last_result   <= s2_tag_r.last_elem;
    end
  end

endmodule

@@ sv/matrix_multiply_4x4.sv @@
`timescale 1ns / 1ps
// matrix_multiply_4x4: top level of the Q16.16 4x4 matrix multiplier.
// Depends on mm4_pkg, mm4_front, mm4_cmdq and mm4_back.
//
// Usage
//   in_*  : one request loads one element of A (target_matrix 0) or B (1).
//           A request with start_multiply set is stored, then P = A * B runs.
//   out_* : DIM*DIM product elements in row-major order, last_result on the
//           final one. Both channels are valid/ready; a request or result is
//           taken on a clock edge where valid and ready are both high.
// Timing
//   Requests go into a 4-deep command queue; while no multiply is issuing,
//   the back end stores one load per cycle. A multiply issues one MAC per
//   cycle while the output does not stall (DIM^3 = 64 MACs) through store
//   read, 32x32 multiply and accumulate stages, one result per DIM MACs.
//   No loads are taken from the queue while the MACs issue.
// Reset (rst_n low, synchronous) empties the queue and the pipeline; the
//   operand stores keep stale data and must be loaded before use.
// Stall: while out_ready is low with a result pending, the MAC pipeline
//   freezes; requests are still queued until the queue fills.
module matrix_multiply_4x4 import mm4_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  q_stat_t q_stat;
  cmd_t    q_cmd;
  cmd_t    q_head;
  logic    q_push;
  logic    q_pop;

  // Front: handshake, range check and store address
  mm4_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Decouples request intake from the long multiply phase
  mm4_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // Back: stores, sequencer, MAC pipeline and result register
  mm4_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // The final flag only ever sits on the bottom-right element.
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_result |->
      out_item.product_row == 2'(DIM - 1) && out_item.product_col == 2'(DIM - 1))
    else $error("last_result on a non-final product element");

  // Queue occupancy stays within its depth.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= CQ_CNT_W'(CQ_DEPTH))
    else $error("command queue count out of range");

  // A full queue must hold off the input side.
  a_q_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_ready && !q_push)
    else $error("request accepted into a full queue");

  // Synchronous reset leaves no result pending and the queue empty.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && q_stat.empty)
    else $error("state not cleared by reset");

endmodule
